>>> rtl/arce_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the admin ring completion engine.
// Depends on nothing; every other file of the block imports it.
package arce_pkg;

  // Default ring depth and the span that the 4-bit entry index can address.
  localparam int RING_DEPTH_DEF = 16;
  localparam int ENTRY_W        = 4;
  localparam int SLOT_SPAN      = 2 ** ENTRY_W;

  // Configuration port sizing.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes.
  localparam logic [1:0] REG_DOORBELL_BASE = 2'd0;
  localparam logic [1:0] REG_LINK_CODE     = 2'd1;
  localparam logic [1:0] REG_RESET_CODE    = 2'd2;

  // Operation codes of an input item.
  localparam logic [1:0] OP_POST      = 2'd0;
  localparam logic [1:0] OP_DONE_WR   = 2'd1;
  localparam logic [1:0] OP_EVENT_WR  = 2'd2;
  localparam logic [1:0] OP_SERVICE   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_POST    = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_CREDITS = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FW_DOWN  = 2'd2;
  localparam logic [1:0] ST_STOPPING = 2'd3;

  // One input item.
  typedef struct packed {
    logic [1:0]         operation;
    logic               fw_running;
    logic               stopping;
    logic [ENTRY_W-1:0] entry_index;
    logic               entry_color;
    logic [63:0]        event_id;
    logic [15:0]        event_code;
  } arce_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [ENTRY_W-1:0] slot_index;
    logic [15:0]        doorbell_word;
    logic [63:0]        out_event_id;
    logic [15:0]        out_event_code;
    logic               forward;
    logic [5:0]         credit_count;
    logic               last;
  } arce_out_t;

  // Configuration register values seen by the datapath.
  typedef struct packed {
    logic [15:0] doorbell_base;
    logic [15:0] link_change_code;
    logic [15:0] reset_code;
  } arce_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_post;
    logic take_done_wr;
    logic take_event_wr;
    logic take_stop;
    logic start_svc;
    logic evt_step;
    logic clr_guard;
    logic cmp_step;
    logic cred_emit;
  } arce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic evt_new;
    logic cmp_match;
    logic guard_done;
    logic ring_busy;
  } arce_sts_t;

endpackage

>>> rtl/arce_regs.sv
`timescale 1ns / 1ps
// Configuration registers behind an APB-style port.
// Depends on arce_pkg for the register indexes and the config struct.
module arce_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [arce_pkg::CFG_AW-1:0] paddr,
  input  logic [arce_pkg::CFG_DW-1:0] pwdata,
  output logic [arce_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output arce_pkg::arce_cfg_t        cfg
);
  import arce_pkg::*;

  logic [15:0] doorbell_base_r, doorbell_base_nxt;
  logic [15:0] link_code_r, link_code_nxt;
  logic [15:0] reset_code_r, reset_code_nxt;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // A write lands in the access phase; unknown addresses are ignored.
  always_comb begin
    doorbell_base_nxt = doorbell_base_r;
    link_code_nxt     = link_code_r;
    reset_code_nxt    = reset_code_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DOORBELL_BASE: doorbell_base_nxt = pwdata[15:0];
        REG_LINK_CODE:     link_code_nxt     = pwdata[15:0];
        REG_RESET_CODE:    reset_code_nxt    = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      doorbell_base_r <= 16'd0;
      link_code_r     <= 16'd1;
      reset_code_r    <= 16'd2;
    end else begin
      doorbell_base_r <= doorbell_base_nxt;
      link_code_r     <= link_code_nxt;
      reset_code_r    <= reset_code_nxt;
    end
  end

  // Read data is zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_DOORBELL_BASE: prdata = CFG_DW'(doorbell_base_r);
      REG_LINK_CODE:     prdata = CFG_DW'(link_code_r);
      REG_RESET_CODE:    prdata = CFG_DW'(reset_code_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.doorbell_base    = doorbell_base_r;
  assign cfg.link_change_code = link_code_r;
  assign cfg.reset_code       = reset_code_r;

endmodule

>>> rtl/arce_datapath.sv
`timescale 1ns / 1ps
// Ring pointers, completion colors, event entries and the result register.
// Depends on arce_pkg; driven by commands from arce_ctrl.
module arce_datapath #(
  parameter int RING_DEPTH = arce_pkg::RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arce_pkg::arce_in_t  in_data,
  input  arce_pkg::arce_cfg_t cfg,
  input  arce_pkg::arce_cmd_t cmd,
  output arce_pkg::arce_sts_t sts,
  input  logic                out_stall,
  output logic                out_valid,
  output arce_pkg::arce_out_t out_data
);
  import arce_pkg::*;

  localparam int IW    = $clog2(RING_DEPTH);
  // Only slots the 4-bit entry index can reach are ever written.
  localparam int STORE = (RING_DEPTH < SLOT_SPAN) ? RING_DEPTH : SLOT_SPAN;
  localparam int SW    = $clog2(STORE);
  localparam int GW    = $clog2(RING_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  logic [IW-1:0]    cmd_head_r, cmd_head_nxt;
  logic [IW-1:0]    cmd_tail_r, cmd_tail_nxt;
  logic [IW-1:0]    done_tail_r, done_tail_nxt;
  logic [IW-1:0]    event_tail_r, event_tail_nxt;
  logic             exp_color_r, exp_color_nxt;
  logic [63:0]      last_seen_r, last_seen_nxt;
  logic [GW-1:0]    guard_r, guard_nxt;
  logic [5:0]       count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  arce_out_t        out_data_r, out_data_nxt;
  logic [STORE-1:0] done_colors_r;
  logic [STORE-1:0] ev_vld_r;
  logic [63:0]      ev_id_r [STORE];
  logic [15:0]      ev_code_r [STORE];

  logic             wr_in_range;
  logic [SW-1:0]    wr_idx;
  logic             ev_tail_in;
  logic [SW-1:0]    ev_rd_idx;
  logic             dn_tail_in;
  logic [SW-1:0]    dn_rd_idx;
  logic [63:0]      cur_id;
  logic [15:0]      cur_code;
  logic             cur_color;
  logic [IW-1:0]    head_adv;
  logic             no_space;
  logic             load;
  arce_out_t        res;

  // Device writes beyond the ring are dropped.
  assign wr_in_range = (32'(in_data.entry_index) < RING_DEPTH);
  assign wr_idx      = in_data.entry_index[SW-1:0];

  // Entry reads at the walk pointers; unwritten entries read as zero.
  assign ev_tail_in = (32'(event_tail_r) < STORE);
  assign ev_rd_idx  = event_tail_r[SW-1:0];
  assign dn_tail_in = (32'(done_tail_r) < STORE);
  assign dn_rd_idx  = done_tail_r[SW-1:0];

  always_comb begin
    cur_id    = '0;
    cur_code  = '0;
    cur_color = 1'b0;
    if (ev_tail_in && ev_vld_r[ev_rd_idx]) begin
      cur_id   = ev_id_r[ev_rd_idx];
      cur_code = ev_code_r[ev_rd_idx];
    end
    if (dn_tail_in) begin
      cur_color = done_colors_r[dn_rd_idx];
    end
  end

  // Free-space check: one slot always stays reserved.
  assign head_adv = ring_next(cmd_head_r);
  assign no_space = (head_adv == cmd_tail_r);

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.evt_new    = (cur_id > last_seen_r);
  assign sts.cmp_match  = (cur_color == exp_color_r);
  assign sts.guard_done = (guard_r == GW'(RING_DEPTH));
  assign sts.ring_busy  = (cmd_tail_r != cmd_head_r);

  // Result formation for whichever command loads the output register.
  always_comb begin
    res  = '0;
    load = 1'b0;
    if (cmd.take_post) begin
      load      = 1'b1;
      res.kind  = KIND_POST;
      res.last  = 1'b1;
      if (no_space) begin
        res.status = ST_NO_SPACE;
      end else if (!in_data.fw_running) begin
        res.status = ST_FW_DOWN;
      end else begin
        res.status        = ST_OK;
        res.slot_index    = ENTRY_W'(cmd_head_r);
        res.doorbell_word = cfg.doorbell_base | 16'(head_adv);
      end
    end else if (cmd.take_stop) begin
      load       = 1'b1;
      res.kind   = KIND_CREDITS;
      res.status = ST_STOPPING;
      res.last   = 1'b1;
    end else if (cmd.evt_step) begin
      load               = 1'b1;
      res.kind           = KIND_EVENT;
      res.out_event_id   = cur_id;
      res.out_event_code = cur_code;
      res.forward        = (cur_code == cfg.link_change_code) ||
                           (cur_code == cfg.reset_code);
    end else if (cmd.cmp_step) begin
      load           = 1'b1;
      res.kind       = KIND_DONE;
      res.slot_index = ENTRY_W'(cmd_tail_r);
    end else if (cmd.cred_emit) begin
      load             = 1'b1;
      res.kind         = KIND_CREDITS;
      res.credit_count = count_r;
      res.last         = 1'b1;
    end
  end

  // Next values of pointers, phase, walk counters and the result register.
  always_comb begin
    cmd_head_nxt   = cmd_head_r;
    cmd_tail_nxt   = cmd_tail_r;
    done_tail_nxt  = done_tail_r;
    event_tail_nxt = event_tail_r;
    exp_color_nxt  = exp_color_r;
    last_seen_nxt  = last_seen_r;
    guard_nxt      = guard_r;
    count_nxt      = count_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cmd.take_post && !no_space && in_data.fw_running) begin
      cmd_head_nxt = head_adv;
    end
    if (cmd.start_svc) begin
      guard_nxt = '0;
      count_nxt = '0;
    end
    if (cmd.clr_guard) begin
      guard_nxt = '0;
    end
    if (cmd.evt_step) begin
      last_seen_nxt  = cur_id;
      event_tail_nxt = ring_next(event_tail_r);
      guard_nxt      = guard_r + 1'b1;
      count_nxt      = count_r + 1'b1;
    end
    if (cmd.cmp_step) begin
      cmd_tail_nxt  = ring_next(cmd_tail_r);
      done_tail_nxt = ring_next(done_tail_r);
      guard_nxt     = guard_r + 1'b1;
      count_nxt     = count_r + 1'b1;
      if (done_tail_r == LAST_IDX) begin
        exp_color_nxt = !exp_color_r;
      end
    end
    if (load) begin
      out_data_nxt  = res;
      out_valid_nxt = 1'b1;
    end
  end

  // Control state and completion colors.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_head_r    <= '0;
      cmd_tail_r    <= '0;
      done_tail_r   <= '0;
      event_tail_r  <= '0;
      exp_color_r   <= 1'b1;
      last_seen_r   <= '0;
      guard_r       <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      done_colors_r <= '0;
      ev_vld_r      <= '0;
    end else begin
      cmd_head_r   <= cmd_head_nxt;
      cmd_tail_r   <= cmd_tail_nxt;
      done_tail_r  <= done_tail_nxt;
      event_tail_r <= event_tail_nxt;
      exp_color_r  <= exp_color_nxt;
      last_seen_r  <= last_seen_nxt;
      guard_r      <= guard_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cmd.take_done_wr && wr_in_range) begin
        done_colors_r[wr_idx] <= in_data.entry_color;
      end
      if (cmd.take_event_wr && wr_in_range) begin
        ev_vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  // Event entry contents and the result payload carry no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (cmd.take_event_wr && wr_in_range) begin
      ev_id_r[wr_idx]   <= in_data.event_id;
      ev_code_r[wr_idx] <= in_data.event_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // At most one command loads the result register in a cycle.
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take_post, cmd.take_stop, cmd.evt_step, cmd.cmp_step, cmd.cred_emit}))
    else $error("more than one result load in a cycle");

  // A load never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  // The command tail moves only when a completion is retired.
  a_tail_move: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(cmd_tail_r)) |-> $past(cmd.cmp_step))
    else $error("command tail moved without a retire");

  // The expected phase flips only on a retire at the last slot.
  a_phase_flip: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(exp_color_r)) |->
      ($past(cmd.cmp_step) && $past(done_tail_r) == LAST_IDX))
    else $error("phase flipped outside a wrap");
`endif

endmodule

>>> rtl/arce_ctrl.sv
`timescale 1ns / 1ps
// Controller that sequences posts, device writes and the two service walks.
// Depends on arce_pkg for operation codes and the command/status structs.
module arce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic                stopping,
  input  arce_pkg::arce_sts_t sts,
  output arce_pkg::arce_cmd_t cmd
);
  import arce_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVT,
    S_CMP,
    S_CRED
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  // Items are taken only in idle and only when the result register can load.
  assign in_stall = !((state_r == S_IDLE) && sts.out_free);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (operation)
            OP_POST:     cmd.take_post     = 1'b1;
            OP_DONE_WR:  cmd.take_done_wr  = 1'b1;
            OP_EVENT_WR: cmd.take_event_wr = 1'b1;
            OP_SERVICE: begin
              if (stopping) begin
                cmd.take_stop = 1'b1;
              end else begin
                cmd.start_svc = 1'b1;
                state_nxt     = S_EVT;
              end
            end
            default: ;
          endcase
        end
      end
      // Walk new events, one transfer per cycle while the result register can load.
      S_EVT: begin
        if (!sts.evt_new || sts.guard_done) begin
          cmd.clr_guard = 1'b1;
          state_nxt     = sts.ring_busy ? S_CMP : S_CRED;
        end else if (sts.out_free) begin
          cmd.evt_step = 1'b1;
        end
      end
      // Retire completions while the color matches the phase.
      S_CMP: begin
        if (!sts.cmp_match || sts.guard_done) begin
          state_nxt = S_CRED;
        end else if (sts.out_free) begin
          cmd.cmp_step = 1'b1;
        end
      end
      S_CRED: begin
        if (sts.out_free) begin
          cmd.cred_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // A service that is started is always walking on the next cycle.
  a_svc_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_svc |=> (state_r == S_EVT))
    else $error("service start did not enter the event walk");

  // The credits result always returns the controller to idle.
  a_cred_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cred_emit |=> (state_r == S_IDLE))
    else $error("credits result did not end the service");

  // The completion walk only runs when commands are outstanding at its start.
  a_cmp_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVT && state_nxt == S_CMP) |-> sts.ring_busy)
    else $error("completion walk entered on an empty ring");
`endif

endmodule

>>> rtl/admin_ring_completion_engine.sv
`timescale 1ns / 1ps
// Results: a post reply or refused service is in the output register the cycle after its
// transfer; a service walks new events, then retired completions (skipped when the command ring
// is empty), then loads its credits result; each walk step waits while the output is stalled.
// Flow: posts and device writes keep the controller in idle; the next item is taken once the
// controller is back in idle and the result register can load.
// Reset: synchronous active-low rst_n clears pointers, colors and valid bits; phase starts at one.
module admin_ring_completion_engine #(
  parameter int RING_DEPTH = arce_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  arce_pkg::arce_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output arce_pkg::arce_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arce_pkg::CFG_AW-1:0] paddr,
  input  logic [arce_pkg::CFG_DW-1:0] pwdata,
  output logic [arce_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import arce_pkg::*;

  arce_cfg_t cfg;
  arce_cmd_t cmd;
  arce_sts_t sts;

  // Configuration registers.
  arce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencing of items and walks.
  arce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (in_data.operation),
    .stopping  (in_data.stopping),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Ring state and result formation.
  arce_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> sim/admin_ring_completion_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for admin_ring_completion_engine: directed ring cases, then
// random post/write/service bursts under random idling on both channels.
// Depends on arce_pkg and the engine RTL.
module admin_ring_completion_engine_tb;
  import arce_pkg::*;

  localparam int DEPTH     = 16;
  localparam int PHASES    = 5;
  localparam int PHASE_LEN = 60;
  localparam int SETTLE    = 40;

  // Ring bookkeeping predictor plus the queue of results still owed by the block.
  class ring_book;
    logic [3:0]  cmd_head, cmd_tail, done_tail, evt_tail;
    logic        exp_color;
    logic        done_colors[DEPTH];
    logic [63:0] last_seen;
    logic [63:0] evt_ids[DEPTH];
    logic [15:0] evt_codes[DEPTH];
    logic [15:0] db_base, link_code, rst_code;
    arce_out_t   pending_results[$];
    int          errors;

    function new();
      cmd_head  = '0;
      cmd_tail  = '0;
      done_tail = '0;
      evt_tail  = '0;
      exp_color = 1'b1;
      last_seen = '0;
      for (int i = 0; i < DEPTH; i++) begin
        done_colors[i] = 1'b0;
        evt_ids[i]     = '0;
        evt_codes[i]   = '0;
      end
      db_base   = 16'h0000;
      link_code = 16'h0001;
      rst_code  = 16'h0002;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_DOORBELL_BASE: db_base = val;
        REG_LINK_CODE:     link_code = val;
        REG_RESET_CODE:    rst_code = val;
        default: ;
      endcase
    endfunction

    // Advance the ring state for one accepted input transfer and queue its results.
    function void take_item(arce_in_t it);
      arce_out_t  r;
      logic [3:0] nxt;
      logic [5:0] credits;
      case (it.operation)
        OP_POST: begin
          r = '0;
          r.kind = KIND_POST;
          r.last = 1'b1;
          nxt = cmd_head + 4'd1;
          // One slot always stays empty, so a full ring has head just behind tail.
          if (nxt == cmd_tail) begin
            r.status = ST_NO_SPACE;
          end else if (!it.fw_running) begin
            r.status = ST_FW_DOWN;
          end else begin
            r.status = ST_OK;
            r.slot_index = cmd_head;
            cmd_head = nxt;
            r.doorbell_word = db_base | {12'h000, cmd_head};
          end
          pending_results.push_back(r);
        end
        OP_DONE_WR: done_colors[it.entry_index] = it.entry_color;
        OP_EVENT_WR: begin
          evt_ids[it.entry_index]   = it.event_id;
          evt_codes[it.entry_index] = it.event_code;
        end
        default: begin
          r = '0;
          r.kind = KIND_CREDITS;
          r.last = 1'b1;
          if (it.stopping) begin
            r.status = ST_STOPPING;
            pending_results.push_back(r);
          end else begin
            credits = '0;
            // Event walk: report entries while their id keeps growing.
            for (int g = 0; g < DEPTH; g++) begin
              arce_out_t ev;
              if (evt_ids[evt_tail] <= last_seen) break;
              ev = '0;
              ev.kind = KIND_EVENT;
              ev.status = ST_OK;
              ev.out_event_id = evt_ids[evt_tail];
              ev.out_event_code = evt_codes[evt_tail];
              ev.forward = (evt_codes[evt_tail] == link_code) ||
                           (evt_codes[evt_tail] == rst_code);
              pending_results.push_back(ev);
              last_seen = evt_ids[evt_tail];
              evt_tail = evt_tail + 4'd1;
              credits = credits + 6'd1;
            end
            // Completion walk: only entered with commands in flight, then only the
            // phase color ends it.
            if (cmd_tail != cmd_head) begin
              for (int g = 0; g < DEPTH; g++) begin
                arce_out_t dn;
                if (done_colors[done_tail] != exp_color) break;
                dn = '0;
                dn.kind = KIND_DONE;
                dn.status = ST_OK;
                dn.slot_index = cmd_tail;
                pending_results.push_back(dn);
                cmd_tail = cmd_tail + 4'd1;
                if (done_tail == 4'(DEPTH - 1)) exp_color = ~exp_color;
                done_tail = done_tail + 4'd1;
                credits = credits + 6'd1;
              end
            end
            r.credit_count = credits;
            pending_results.push_back(r);
          end
        end
      endcase
    endfunction

    // Printing is capped so that a badly broken block cannot flood the log.
    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compare one accepted result transfer with the oldest expectation.
    task check_result(arce_out_t got);
      arce_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected, kind %0d", got.kind));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("status", got.status, want.status);
        check_field("slot_index", got.slot_index, want.slot_index);
        check_field("doorbell_word", got.doorbell_word, want.doorbell_word);
        check_field("out_event_id", got.out_event_id, want.out_event_id);
        check_field("out_event_code", got.out_event_code, want.out_event_code);
        check_field("forward", got.forward, want.forward);
        check_field("credit_count", got.credit_count, want.credit_count);
        check_field("last", got.last, want.last);
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  arce_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  arce_out_t           out_data;
  logic                psel, penable, pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  ring_book sb = new();
  int       sent_items = 0;
  logic     steady = 1'b0;

  admin_ring_completion_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Result side: check each accepted transfer, then pick the next stall value.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= !steady && ($urandom_range(99) < 36);
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic arce_in_t rand_item(logic [1:0] op);
    arce_in_t it;
    it.operation   = op;
    it.fw_running  = 1'($urandom_range(1));
    it.stopping    = 1'($urandom_range(1));
    it.entry_index = 4'($urandom_range(15));
    it.entry_color = 1'($urandom_range(1));
    it.event_id    = {$urandom, $urandom};
    it.event_code  = 16'($urandom);
    return it;
  endfunction

  // Present one item, with random idle cycles ahead of it, and wait for its transfer.
  task automatic send(arce_in_t it);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(it);
    sent_items++;
  endtask

  // Let every owed result arrive, then give a trailing device write time to land.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup and access phases, then psel low before returning so that writes never run together.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // A consistent round of host and device activity: posts, matching completions,
  // growing events, some noise, then usually a service.
  task automatic run_burst();
    arce_in_t    it;
    int          n;
    logic [3:0]  in_flight;
    logic [4:0]  pos;
    logic [63:0] id;
    n = $urandom_range(4);
    for (int k = 0; k < n; k++) begin
      it = rand_item(OP_POST);
      it.fw_running = ($urandom_range(9) != 0);
      send(it);
    end
    in_flight = sb.cmd_head - sb.cmd_tail;
    n = $urandom_range(in_flight);
    for (int k = 0; k < n; k++) begin
      it = rand_item(OP_DONE_WR);
      pos = 5'(sb.done_tail + k);
      it.entry_index = pos[3:0];
      // Entries past the wrap carry the next phase color.
      it.entry_color = sb.exp_color ^ pos[4];
      send(it);
    end
    n = $urandom_range(5);
    id = sb.last_seen;
    for (int k = 0; k < n; k++) begin
      it = rand_item(OP_EVENT_WR);
      if (id < 64'hFFFF_FFFF_FFFF_0000) id = id + 64'd1 + 64'($urandom_range(1000));
      it.event_id = id;
      it.entry_index = 4'(sb.evt_tail + k);
      case ($urandom_range(3))
        0: it.event_code = sb.link_code;
        1: it.event_code = sb.rst_code;
        default: ;
      endcase
      send(it);
    end
    if ($urandom_range(3) == 0) send(rand_item(2'($urandom_range(3))));
    if ($urandom_range(4) != 0) begin
      it = rand_item(OP_SERVICE);
      it.stopping = ($urandom_range(7) == 0);
      send(it);
    end
  endtask

  initial begin
    arce_in_t    it;
    logic [15:0] db, lc, rc;
    int          target;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: firmware down, stopping, empty service, events with both forward
    // codes and a stale lower id, one post with its completion, then a full ring.
    it = rand_item(OP_POST);
    it.fw_running = 1'b0;
    send(it);
    it = rand_item(OP_SERVICE);
    it.stopping = 1'b1;
    send(it);
    it = rand_item(OP_SERVICE);
    it.stopping = 1'b0;
    send(it);
    it = rand_item(OP_EVENT_WR);
    it.entry_index = 4'd0;
    it.event_id = 64'd5;
    it.event_code = sb.link_code;
    send(it);
    it = rand_item(OP_EVENT_WR);
    it.entry_index = 4'd1;
    it.event_id = 64'd9;
    it.event_code = sb.rst_code;
    send(it);
    it = rand_item(OP_EVENT_WR);
    it.entry_index = 4'd2;
    it.event_id = 64'd3;
    it.event_code = 16'hFFFF;
    send(it);
    it = rand_item(OP_POST);
    it.fw_running = 1'b1;
    send(it);
    it = rand_item(OP_DONE_WR);
    it.entry_index = 4'd0;
    it.entry_color = 1'b1;
    send(it);
    it = rand_item(OP_DONE_WR);
    it.entry_index = 4'd15;
    it.entry_color = 1'b1;
    send(it);
    it = rand_item(OP_SERVICE);
    it.stopping = 1'b0;
    send(it);
    // Fill the command ring; the last post finds no space even with firmware down.
    for (int k = 0; k < DEPTH; k++) begin
      it = rand_item(OP_POST);
      it.fw_running = (k != DEPTH - 1);
      send(it);
    end
    drain();

    // Random phases, each under its own register setting; one phase runs without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          db = 16'hFFFF;
          lc = 16'hFFFF;
          rc = 16'h0000;
        end
        1: begin
          db = 16'h0000;
          lc = 16'h0000;
          rc = 16'hFFFF;
        end
        default: begin
          db = 16'($urandom);
          lc = 16'($urandom);
          rc = 16'($urandom);
        end
      endcase
      write_reg(REG_DOORBELL_BASE, db);
      write_reg(REG_LINK_CODE, lc);
      write_reg(REG_RESET_CODE, rc);
      steady = (phase == 1);
      target = sent_items + PHASE_LEN;
      while (sent_items < target) run_burst();
      drain();
    end
    steady = 1'b0;

    // Largest possible event id at the walk position, then a service to report it.
    it = rand_item(OP_EVENT_WR);
    it.entry_index = sb.evt_tail;
    it.event_id = '1;
    send(it);
    it = rand_item(OP_SERVICE);
    it.stopping = 1'b0;
    send(it);
    drain();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
